/* sv/dbms_pkg.sv */
// Package with shared types and constants of the depth boundary mode select block.
package dbms_pkg;

   localparam int ValueWidth    = 8;
   localparam int DistWidth     = 12;
   localparam int CountWidth    = 9;
   localparam int DsumWidth     = 20;
   localparam int WeightWidth   = 16;
   localparam int FracWidth     = 13;
   localparam int MeanWidth     = 29;
   localparam int ScoreWidth    = 31;
   localparam int TableDepth    = 256;
   localparam int IndexWidth    = 8;
   localparam int UsedWidth     = 9;
   localparam int CountLimit    = 511;
   localparam int DsumLimit     = 1048575;
   // A 28-bit mean difference scaled by 4096 needs a 40-bit dividend.
   localparam int DivWidth      = 40;
   localparam int DivSteps      = 40;
   localparam int DefaultWeight = 4096;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_FREQUENCY = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_COLOR     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_SPACE     = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_UPDATE,
      ST_PASS1_RD,
      ST_PASS1_WAIT,
      ST_PASS1_DIV,
      ST_PASS2_RD,
      ST_PASS2_WAIT,
      ST_PASS2_DIV,
      ST_PASS2_MUL,
      ST_DONE
   } state_type;

   // Request from the sequencer to the shared divider.
   typedef struct packed {
      logic                start;
      logic [DivWidth-1:0] numer;
      logic [DivWidth-1:0] denom;
   } div_req_type;

   // Status back from the shared divider.
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DivWidth-1:0] quot;
   } div_rsp_type;

endpackage

/* sv/dbms_ram.sv */
// Generic single-port RAM with registered read.
module dbms_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read at one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dbms_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module dbms_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dbms_pkg::div_req_type div_req,
   output dbms_pkg::div_rsp_type div_rsp
);

   localparam int W = dbms_pkg::DivWidth;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] den_ff, den_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W:0]   trial;

   // One shift-subtract step per cycle.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.numer;
         den_in  = div_req.denom;
         cnt_in  = 6'(dbms_pkg::DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

/* sv/depth_boundary_mode_select.sv */
// Top level of the depth boundary mode select filter.
//
// Taps of one circular window arrive on the req_ channel, one word each,
// with req_last_tap set on the final tap. Every tap but the first of a
// window searches the table of distinct values entry by entry through a
// single RAM port, and req_stall stays high meanwhile. On the last tap
// the block makes two passes over the table. The first computes each
// mean distance with the shared divider; the second computes three
// normalized terms with the same divider and scores them. A window with
// a single distinct value skips both passes and is answered after its
// table update.
// The result word is held in an output register on the rsp_ channel; while
// rsp_stall is high it holds, and the next tap is taken only after the
// result has been taken. Weights must be written through csr_ while idle;
// the block does not enforce this. Reset is synchronous: the table empties
// and the weights return to 1.0. The table RAM needs no clearing pass, only
// entries of the current window are read.
module depth_boundary_mode_select #(
   parameter int TableDepth = dbms_pkg::TableDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dbms_pkg::ValueWidth-1:0]      req_tap_value,
   input  logic [dbms_pkg::DistWidth-1:0]       req_tap_distance,
   input  logic [dbms_pkg::ValueWidth-1:0]      req_centre_value,
   input  logic                                 req_last_tap,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dbms_pkg::ValueWidth-1:0]      rsp_filtered_pixel,
   input  logic                                 csr_write,
   input  logic [dbms_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dbms_pkg::WeightWidth-1:0]     csr_data
);

   localparam int IW  = $clog2(TableDepth);
   localparam int UW  = IW + 1;
   localparam int VW  = dbms_pkg::ValueWidth;
   localparam int CW  = dbms_pkg::CountWidth;
   localparam int SW  = dbms_pkg::DsumWidth;
   localparam int MW  = dbms_pkg::MeanWidth;
   localparam int DW  = dbms_pkg::DivWidth;
   localparam int FW  = dbms_pkg::FracWidth;
   localparam int WW  = dbms_pkg::WeightWidth;
   localparam int QW  = dbms_pkg::ScoreWidth;
   localparam int EW  = VW + CW + SW;
   localparam int ONE = 4096;

   dbms_pkg::state_type state_ff, state_in;

   logic [WW-1:0] wf_ff, wc_ff, ws_ff;
   logic [UW-1:0] used_ff, used_in;
   logic [VW-1:0] centre_ff, centre_in;
   logic [VW-1:0] tv_ff;
   logic [dbms_pkg::DistWidth-1:0] td_ff;
   logic          last_ff;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [1:0]    term_ff, term_in;
   logic [VW-1:0] rsp_ff, rsp_in;
   logic          rspv_ff, rspv_in;

   logic [CW-1:0] cmax_ff, cmin_ff, cmax_in, cmin_in;
   logic [VW-1:0] dmax_ff, dmin_ff, dmax_in, dmin_in;
   logic [MW-1:0] mmax_ff, mmin_ff, mmax_in, mmin_in;
   logic [QW-1:0] best_ff, best_in;
   logic [VW-1:0] pick_ff, pick_in;
   logic [FW-1:0] occ_ff, col_ff, spc_ff, occ_in, col_in, spc_in;
   logic [QW-1:0] acc_ff, acc_in;

   logic          tab_we, mean_we;
   logic [IW-1:0] tab_addr;
   logic [EW-1:0] tab_wdata, tab_rdata;
   logic [MW-1:0] mean_rdata;
   logic [VW-1:0] e_val;
   logic [CW-1:0] e_cnt;
   logic [SW-1:0] e_sum;
   logic [SW:0]   sum_add;
   logic [VW-1:0] e_diff;
   logic [MW-1:0] div_q;

   dbms_pkg::div_req_type div_req;
   dbms_pkg::div_rsp_type div_rsp;

   assign e_val  = tab_rdata[EW-1 -: VW];
   assign e_cnt  = tab_rdata[SW +: CW];
   assign e_sum  = tab_rdata[SW-1:0];
   assign e_diff = (e_val > centre_ff) ? e_val - centre_ff : centre_ff - e_val;
   assign sum_add = {1'b0, e_sum} + {{(SW+1-dbms_pkg::DistWidth){1'b0}}, td_ff};
   assign div_q  = div_rsp.quot[MW-1:0];

   dbms_ram #(.Width(EW), .Depth(TableDepth)) u_table (
      .clock(clock), .wr_en(tab_we), .addr(tab_addr),
      .wr_data(tab_wdata), .rd_data(tab_rdata)
   );

   dbms_ram #(.Width(MW), .Depth(TableDepth)) u_mean (
      .clock(clock), .wr_en(mean_we), .addr(ptr_ff),
      .wr_data(div_q), .rd_data(mean_rdata)
   );

   dbms_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // Handshake outputs.
   assign req_stall          = (state_ff != dbms_pkg::ST_IDLE) || rspv_ff;
   assign rsp_valid          = rspv_ff;
   assign rsp_filtered_pixel = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbms_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in = (used_ff == '0) ? dbms_pkg::ST_UPDATE : dbms_pkg::ST_SEARCH;
            end
         end
         dbms_pkg::ST_SEARCH:      state_in = dbms_pkg::ST_SEARCH_WAIT;
         dbms_pkg::ST_SEARCH_WAIT: begin
            if (e_val == tv_ff || {1'b0, ptr_ff} == used_ff - UW'(1)) begin
               state_in = dbms_pkg::ST_UPDATE;
            end else begin
               state_in = dbms_pkg::ST_SEARCH;
            end
         end
         dbms_pkg::ST_UPDATE: begin
            if (!last_ff) begin
               state_in = dbms_pkg::ST_IDLE;
            end else if (used_in == UW'(1)) begin
               state_in = dbms_pkg::ST_DONE;
            end else begin
               state_in = dbms_pkg::ST_PASS1_RD;
            end
         end
         dbms_pkg::ST_PASS1_RD:   state_in = dbms_pkg::ST_PASS1_WAIT;
         dbms_pkg::ST_PASS1_WAIT: state_in = dbms_pkg::ST_PASS1_DIV;
         dbms_pkg::ST_PASS1_DIV: begin
            if (div_rsp.done) begin
               state_in = ({1'b0, ptr_ff} == used_ff - UW'(1)) ?
                          dbms_pkg::ST_PASS2_RD : dbms_pkg::ST_PASS1_RD;
            end
         end
         dbms_pkg::ST_PASS2_RD:   state_in = dbms_pkg::ST_PASS2_WAIT;
         dbms_pkg::ST_PASS2_WAIT: state_in = dbms_pkg::ST_PASS2_DIV;
         dbms_pkg::ST_PASS2_DIV: begin
            if ((div_rsp.done || !div_rsp.busy) && term_ff == 2'd2) begin
               state_in = dbms_pkg::ST_PASS2_MUL;
            end
         end
         dbms_pkg::ST_PASS2_MUL: begin
            if (term_ff == 2'd2) begin
               state_in = ({1'b0, ptr_ff} == used_ff - UW'(1)) ?
                          dbms_pkg::ST_DONE : dbms_pkg::ST_PASS2_RD;
            end
         end
         dbms_pkg::ST_DONE:       state_in = dbms_pkg::ST_IDLE;
         default:                 state_in = dbms_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      logic [CW:0]    cnum, cden;
      logic [VW:0]    dnum, dden;
      logic [MW-1:0]  mnum, mden;
      logic [WW-1:0]  wsel;
      logic [FW-1:0]  fsel;
      logic [CW-1:0]  cnt_new;
      logic [SW-1:0]  sum_new;
      used_in   = used_ff;
      centre_in = centre_ff;
      ptr_in    = ptr_ff;
      term_in   = term_ff;
      rsp_in    = rsp_ff;
      rspv_in   = rspv_ff && rsp_stall;
      cmax_in   = cmax_ff;
      cmin_in   = cmin_ff;
      dmax_in   = dmax_ff;
      dmin_in   = dmin_ff;
      mmax_in   = mmax_ff;
      mmin_in   = mmin_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      occ_in    = occ_ff;
      col_in    = col_ff;
      spc_in    = spc_ff;
      acc_in    = acc_ff;
      tab_we    = 1'b0;
      tab_addr  = ptr_ff;
      tab_wdata = {tv_ff, CW'(1), SW'(td_ff)};
      mean_we   = 1'b0;
      div_req   = '0;
      cnum = {1'b0, e_cnt} - {1'b0, cmin_ff};
      cden = {1'b0, cmax_ff} - {1'b0, cmin_ff};
      dnum = {1'b0, dmax_ff} - {1'b0, e_diff};
      dden = {1'b0, dmax_ff} - {1'b0, dmin_ff};
      mnum = mmax_ff - mean_rdata;
      mden = mmax_ff - mmin_ff;
      cnt_new = (e_cnt < CW'(dbms_pkg::CountLimit)) ? e_cnt + CW'(1) : e_cnt;
      sum_new = (sum_add > (SW+1)'(dbms_pkg::DsumLimit)) ? SW'(dbms_pkg::DsumLimit)
                                                         : sum_add[SW-1:0];
      wsel = (term_ff == 2'd0) ? wf_ff : ((term_ff == 2'd1) ? wc_ff : ws_ff);
      fsel = (term_ff == 2'd0) ? occ_ff : ((term_ff == 2'd1) ? col_ff : spc_ff);
      case (state_ff)
         dbms_pkg::ST_IDLE: begin
            ptr_in = '0;
            if (req_valid && !req_stall && used_ff == '0) begin
               centre_in = req_centre_value;
            end
         end
         dbms_pkg::ST_SEARCH_WAIT: begin
            if (e_val != tv_ff && {1'b0, ptr_ff} != used_ff - UW'(1)) begin
               ptr_in = ptr_ff + IW'(1);
            end
         end
         dbms_pkg::ST_UPDATE: begin
            tab_we = 1'b1;
            if (used_ff != '0 && e_val == tv_ff) begin
               tab_wdata = {tv_ff, cnt_new, sum_new};
            end else begin
               tab_addr = used_ff[IW-1:0];
               used_in  = used_ff + UW'(1);
            end
            ptr_in  = '0;
            cmax_in = '0;
            cmin_in = CW'(dbms_pkg::CountLimit);
            dmax_in = '0;
            dmin_in = '1;
            mmax_in = '0;
            mmin_in = '1;
            best_in = '0;
            pick_in = centre_ff;
            if (last_ff) begin
               if (used_in == UW'(1)) begin
                  rsp_in = tab_wdata[EW-1 -: VW];
               end
            end
         end
         dbms_pkg::ST_PASS1_WAIT: begin
            div_req.start = 1'b1;
            div_req.numer = DW'({e_sum, 8'd0});
            div_req.denom = DW'((e_cnt == '0) ? CW'(1) : e_cnt);
            if (e_cnt > cmax_ff) cmax_in = e_cnt;
            if (e_cnt < cmin_ff) cmin_in = e_cnt;
            if (e_diff > dmax_ff) dmax_in = e_diff;
            if (e_diff < dmin_ff) dmin_in = e_diff;
         end
         dbms_pkg::ST_PASS1_DIV: begin
            if (div_rsp.done) begin
               mean_we = 1'b1;
               if (div_q > mmax_ff) mmax_in = div_q;
               if (div_q < mmin_ff) mmin_in = div_q;
               ptr_in = ({1'b0, ptr_ff} == used_ff - UW'(1)) ? '0 : ptr_ff + IW'(1);
            end
         end
         dbms_pkg::ST_PASS2_WAIT: begin
            term_in = 2'd0;
            occ_in  = '0;
            col_in  = '0;
            spc_in  = '0;
            acc_in  = '0;
            div_req.start = (cden != '0);
            div_req.numer = DW'({cnum, 12'd0});
            div_req.denom = DW'(cden);
            if (cden == '0) term_in = 2'd1;
            if (cden == '0 && dden != '0) begin
               div_req.start = 1'b1;
               div_req.numer = DW'({dnum, 12'd0});
               div_req.denom = DW'(dden);
            end
            if (cden == '0 && dden == '0) begin
               term_in = 2'd2;
               div_req.start = (mden != '0);
               div_req.numer = DW'({mnum[MW-2:0], 12'd0});
               div_req.denom = DW'(mden);
            end
         end
         dbms_pkg::ST_PASS2_DIV: begin
            // Each term waits on the divider unless its range is zero.
            if (div_rsp.done || !div_rsp.busy) begin
               if (div_rsp.done) begin
                  case (term_ff)
                     2'd0:    occ_in = FW'(div_q);
                     2'd1:    col_in = FW'(div_q);
                     default: spc_in = FW'(div_q);
                  endcase
               end
               if (term_ff == 2'd0) begin
                  term_in = 2'd1;
                  if (dden != '0) begin
                     div_req.start = 1'b1;
                     div_req.numer = DW'({dnum, 12'd0});
                     div_req.denom = DW'(dden);
                  end
               end else if (term_ff == 2'd1) begin
                  term_in = 2'd2;
                  if (mden != '0) begin
                     div_req.start = 1'b1;
                     div_req.numer = DW'({mnum[MW-2:0], 12'd0});
                     div_req.denom = DW'(mden);
                  end
               end else begin
                  term_in = 2'd0;
               end
            end
         end
         dbms_pkg::ST_PASS2_MUL: begin
            // One weight product per cycle into the score.
            acc_in  = acc_ff + QW'(wsel * fsel);
            term_in = term_ff + 2'd1;
            if (term_ff == 2'd2) begin
               term_in = 2'd0;
               if (acc_in > best_ff) begin
                  best_in = acc_in;
                  pick_in = e_val;
               end
               ptr_in = ptr_ff + IW'(1);
               rsp_in = (acc_in > best_ff) ? e_val : pick_ff;
            end
         end
         dbms_pkg::ST_DONE: begin
            rspv_in = 1'b1;
            used_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Sequencer and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dbms_pkg::ST_IDLE;
         used_ff   <= '0;
         centre_ff <= '0;
         rspv_ff   <= 1'b0;
         wf_ff     <= WW'(dbms_pkg::DefaultWeight);
         wc_ff     <= WW'(dbms_pkg::DefaultWeight);
         ws_ff     <= WW'(dbms_pkg::DefaultWeight);
         term_ff   <= '0;
         ptr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         centre_ff <= centre_in;
         rspv_ff   <= rspv_in;
         term_ff   <= term_in;
         ptr_ff    <= ptr_in;
         if (csr_write) begin
            case (csr_index)
               dbms_pkg::CSR_WEIGHT_FREQUENCY: wf_ff <= csr_data;
               dbms_pkg::CSR_WEIGHT_COLOR:     wc_ff <= csr_data;
               dbms_pkg::CSR_WEIGHT_SPACE:     ws_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == dbms_pkg::ST_IDLE && req_valid && !req_stall) begin
         tv_ff   <= req_tap_value;
         td_ff   <= req_tap_distance;
         last_ff <= req_last_tap;
      end
      rsp_ff  <= rsp_in;
      cmax_ff <= cmax_in;
      cmin_ff <= cmin_in;
      dmax_ff <= dmax_in;
      dmin_ff <= dmin_in;
      mmax_ff <= mmax_in;
      mmin_ff <= mmin_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      occ_ff  <= occ_in;
      col_ff  <= col_in;
      spc_ff  <= spc_in;
      acc_ff  <= acc_in;
   end

   localparam int OneCheck = ONE;

   // A result appears only when the sequencer finishes a window.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rspv_ff) |-> $past(state_ff) == dbms_pkg::ST_DONE)
      else $error("result raised outside window end");

   // The table never overflows.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TableDepth))
      else $error("table overflow");

   // Normalized terms never exceed one while they are scored.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == dbms_pkg::ST_PASS2_MUL |->
         occ_ff <= FW'(OneCheck) && col_ff <= FW'(OneCheck) && spc_ff <= FW'(OneCheck))
      else $error("term above one");

   // The divider is started only while idle.
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy || div_rsp.done)
      else $error("divider restarted while busy");

endmodule
